// ===== hdl/aeap_pkg.sv =====
// Shared types, constants and the arctangent table for the equal-area projection.
// Used by every cell module and by the top level; depends on nothing.
package aeap_pkg;

  localparam int unsigned CW = 34;           // CORDIC word width
  localparam int unsigned DEF_CORDIC_STAGES = 24;
  localparam int unsigned DEF_FRACTION_BITS = 8;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam int unsigned SQ_STEPS = 31;     // root bits of a 62-bit radicand
  localparam int unsigned SQ_RW = 34;        // square root remainder width
  localparam int unsigned Q_BITS = 31;       // quotient bits
  localparam logic [31:0] REG_RESET_SCALE = 32'd72000;

  typedef enum logic [1:0] {
    REG_CENTER_RA  = 2'd0,
    REG_CENTER_DEC = 2'd1,
    REG_SCALE      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } sincos_t;

  typedef struct packed {
    logic [SQ_RW-1:0]    rem;
    logic [SQ_STEPS-1:0] root;
    logic [2*SQ_STEPS-1:0] rad;
  } sqrt_t;

  function automatic logic [31:0] atan_val(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Angles in the left half plane are turned by half a turn first.
  function automatic logic angle_flip(input logic [31:0] a);
    return a[31] ^ a[30];
  endfunction

  function automatic cordic_t cordic_init(input logic [31:0] a);
    cordic_t     r;
    logic [31:0] b;
    b   = angle_flip(a) ? (a ^ 32'h8000_0000) : a;
    r.x = GAIN_Q30;
    r.y = '0;
    r.z = CW'($signed(b));
    return r;
  endfunction

  function automatic sincos_t cordic_out(input cordic_t v, input logic flip);
    sincos_t r;
    r.c = flip ? -v.x : v.x;
    r.s = flip ? -v.y : v.y;
    return r;
  endfunction

endpackage

// ===== hdl/azimuthal_equal_area_projection.sv =====
// Throughput: one item per cycle unless the chain holds; every step (CORDIC rotation,
//   root bit, quotient bit) is its own cell, so a new item follows in the next cycle.
// The whole chain advances together; it holds only while a result waits at the output.
// Reset: asynchronous, active low; clears the valid line and sets the registers to
//   center_ra 0, center_dec 0, scale 72000.
module azimuthal_equal_area_projection #(
  parameter int unsigned CORDIC_STAGES = aeap_pkg::DEF_CORDIC_STAGES,
  parameter int unsigned FRACTION_BITS = aeap_pkg::DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: [31:0] star_ra, [63:32] star_dec
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // master side: [30:0] plane_x, [61:31] plane_y, [63:62] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  // master side user: [0] valid_res
  output logic        m_axis_tuser,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import aeap_pkg::*;

  localparam int unsigned C   = CORDIC_STAGES;
  localparam int unsigned PW  = 2 * CW;              // full product width
  localparam int unsigned NW  = CW + 23;             // scaled numerator width
  localparam int unsigned DW  = NW + FRACTION_BITS + 8;
  // stage positions along the valid line
  localparam int unsigned SQ0 = C + 5;
  localparam int unsigned DV0 = SQ0 + SQ_STEPS;
  localparam int unsigned NST = DV0 + 1 + Q_BITS + 1;

  localparam logic [Q_BITS-1:0] OUT_LIM = Q_BITS'(32'h2000_0000);

  // ---------------------------------------------------------------- registers
  logic [31:0] center_ra_q, center_dec_q;
  logic [19:0] scale_q;
  logic        wr;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_ra_q  <= '0;
      center_dec_q <= '0;
      scale_q      <= REG_RESET_SCALE[19:0];
    end else if (wr) begin
      unique case (widx)
        REG_CENTER_RA:  center_ra_q  <= pwdata;
        REG_CENTER_DEC: center_dec_q <= pwdata;
        REG_SCALE:      scale_q      <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_CENTER_RA:  prdata = center_ra_q;
      REG_CENTER_DEC: prdata = center_dec_q;
      REG_SCALE:      prdata = {12'd0, scale_q};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic           en;
  logic [NST-1:0] vld_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------- entry
  // Three rotators run side by side: star hour angle, star declination (or the
  // polar half angle at a pole centre) and the centre declination.
  typedef struct packed {
    logic flip_l;
    logic flip_p;
    logic flip_d;
    logic polar;
    logic north;
  } cside_t;

  logic [31:0] lam, pang, sdec;
  logic        polar_in, north_in;
  cside_t      cs_in;
  cordic_t     l_in, p_in, d_in;

  always_comb begin
    sdec     = s_axis_tdata[63:32];
    lam      = s_axis_tdata[31:0] - center_ra_q;
    north_in = (center_dec_q == 32'h4000_0000);
    polar_in = north_in || (center_dec_q == 32'hC000_0000);
    // polar: 90 deg/2 minus half the declination, half taken with floor
    pang     = polar_in ? (32'h2000_0000 - {sdec[31], sdec[31:1]}) : sdec;
    l_in     = cordic_init(lam);
    p_in     = cordic_init(pang);
    d_in     = cordic_init(center_dec_q);
    cs_in    = '{flip_l: angle_flip(lam), flip_p: angle_flip(pang),
                 flip_d: angle_flip(center_dec_q), polar: polar_in, north: north_in};
  end

  // ---------------------------------------------------------------- CORDIC chains
  cordic_t l_c [C];
  cordic_t p_c [C];
  cordic_t d_c [C];
  cside_t  cs_q [C];

  for (genvar i = 0; i < C; i++) begin : g_cordic
    cordic_t l_src, p_src, d_src;
    cside_t  s_src;
    if (i == 0) begin : g_first
      assign l_src = l_in;
      assign p_src = p_in;
      assign d_src = d_in;
      assign s_src = cs_in;
    end else begin : g_next
      assign l_src = l_c[i-1];
      assign p_src = p_c[i-1];
      assign d_src = d_c[i-1];
      assign s_src = cs_q[i-1];
    end
    aeap_cordic_cell #(.STAGE(i)) u_l (.clk_i, .en_i(en), .d_i(l_src), .q_o(l_c[i]));
    aeap_cordic_cell #(.STAGE(i)) u_p (.clk_i, .en_i(en), .d_i(p_src), .q_o(p_c[i]));
    aeap_cordic_cell #(.STAGE(i)) u_d (.clk_i, .en_i(en), .d_i(d_src), .q_o(d_c[i]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        cs_q[i] <= s_src;
      end
    end
  end

  // ---------------------------------------------------------------- products
  sincos_t lsc, psc, dsc;
  logic signed [CW-1:0] op1;
  logic signed [PW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [CW-1:0] cd1_q, sd1_q;
  logic                 pol1_q, nor1_q;

  always_comb begin
    lsc = cordic_out(l_c[C-1], cs_q[C-1].flip_l);
    psc = cordic_out(p_c[C-1], cs_q[C-1].flip_p);
    dsc = cordic_out(d_c[C-1], cs_q[C-1].flip_d);
    // north pole radius uses sin of the half angle, all other cases the cosine
    op1 = (cs_q[C-1].polar && cs_q[C-1].north) ? psc.s : psc.c;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= op1 * lsc.c;
      m2_q   <= op1 * lsc.s;
      m3_q   <= dsc.s * psc.s;
      m4_q   <= dsc.c * psc.s;
      cd1_q  <= dsc.c;
      sd1_q  <= dsc.s;
      pol1_q <= cs_q[C-1].polar;
      nor1_q <= cs_q[C-1].north;
    end
  end

  // cc = cos(phi)cos(lam), ux = cos(phi)sin(lam) in Q30 (floor)
  logic signed [CW-1:0] cc2_q, ux2_q, cd2_q, sd2_q;
  logic signed [PW-1:0] m3_2_q, m4_2_q;
  logic                 pol2_q, nor2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cc2_q  <= m1_q[CW+29:30];
      ux2_q  <= m2_q[CW+29:30];
      cd2_q  <= cd1_q;
      sd2_q  <= sd1_q;
      m3_2_q <= m3_q;
      m4_2_q <= m4_q;
      pol2_q <= pol1_q;
      nor2_q <= nor1_q;
    end
  end

  logic signed [PW-1:0] m5_q, m6_q, m3_3_q, m4_3_q;
  logic signed [CW-1:0] cc3_q, ux3_q;
  logic                 pol3_q, nor3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_q   <= cd2_q * cc2_q;
      m6_q   <= sd2_q * cc2_q;
      m3_3_q <= m3_2_q;
      m4_3_q <= m4_2_q;
      cc3_q  <= cc2_q;
      ux3_q  <= ux2_q;
      pol3_q <= pol2_q;
      nor3_q <= nor2_q;
    end
  end

  // denominator in Q60 and y numerator
  logic signed [PW:0]   d60, dif;
  logic signed [CW:0]   vy, ny_src, ccx;
  logic                 dok;
  logic signed [CW:0]   nx4_q, ny4_q;
  logic [2*SQ_STEPS-1:0] rad4_q;
  logic                 val4_q, pol4_q;

  always_comb begin
    d60    = (PW+1)'(64'sh1000_0000_0000_0000) + (PW+1)'(m3_3_q) + (PW+1)'(m5_q);
    dif    = (PW+1)'(m4_3_q) - (PW+1)'(m6_q);
    vy     = dif[CW+30:30];
    ccx    = (CW+1)'(cc3_q);
    dok    = (d60 >= (PW+1)'(2));
    ny_src = pol3_q ? (nor3_q ? -ccx : ccx) : vy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx4_q  <= (CW+1)'(ux3_q);
      ny4_q  <= ny_src;
      rad4_q <= dok ? d60[2*SQ_STEPS:1] : '0;
      val4_q <= pol3_q || dok;
      pol4_q <= pol3_q;
    end
  end

  // scaled numerators; pole centres take twice the scale
  logic signed [NW-1:0] px5, py5, nx5_q, ny5_q;
  logic [2*SQ_STEPS-1:0] rad5_q;
  logic                 val5_q, pol5_q;

  always_comb begin
    px5 = NW'(nx4_q * $signed({1'b0, scale_q}));
    py5 = NW'(ny4_q * $signed({1'b0, scale_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx5_q  <= pol4_q ? (px5 <<< 1) : px5;
      ny5_q  <= pol4_q ? (py5 <<< 1) : py5;
      rad5_q <= rad4_q;
      val5_q <= val4_q;
      pol5_q <= pol4_q;
    end
  end

  // ---------------------------------------------------------------- square root chain
  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic                 valid;
    logic                 polar;
  } sside_t;

  sqrt_t  sq_c [SQ_STEPS];
  sside_t ss_q [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    sqrt_t  q_src;
    sside_t s_src;
    if (i == 0) begin : g_first
      assign q_src = '{rem: '0, root: '0, rad: rad5_q};
      assign s_src = '{nx: nx5_q, ny: ny5_q, valid: val5_q, polar: pol5_q};
    end else begin : g_next
      assign q_src = sq_c[i-1];
      assign s_src = ss_q[i-1];
    end
    aeap_sqrt_cell #(.K(SQ_STEPS - 1 - i)) u_sq (
      .clk_i, .en_i(en), .d_i(q_src), .q_o(sq_c[i])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        ss_q[i] <= s_src;
      end
    end
  end

  // ---------------------------------------------------------------- divider entry
  typedef struct packed {
    logic valid;
    logic negx;
    logic negy;
    logic satx;
    logic saty;
  } dside_t;

  sside_t        sl;
  logic [31:0]   den;
  logic [NW-1:0] magx, magy;
  logic [DW-1:0] mx, my, lim;
  logic [DW-1:0] rx_q, ry_q;
  logic [31:0]   den_q;
  dside_t        dv_q;

  always_comb begin
    sl   = ss_q[SQ_STEPS-1];
    den  = sl.polar ? 32'h4000_0000 : 32'(sq_c[SQ_STEPS-1].root);
    magx = sl.nx[NW-1] ? NW'(-sl.nx) : NW'(sl.nx);
    magy = sl.ny[NW-1] ? NW'(-sl.ny) : NW'(sl.ny);
    mx   = DW'(magx) << FRACTION_BITS;
    my   = DW'(magy) << FRACTION_BITS;
    lim  = DW'(den) << Q_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= mx;
      ry_q  <= my;
      den_q <= den;
      dv_q  <= '{valid: sl.valid, negx: sl.nx[NW-1], negy: sl.ny[NW-1],
                 satx: (mx >= lim), saty: (my >= lim)};
    end
  end

  // ---------------------------------------------------------------- divider chains
  logic [DW-1:0]     xr_c [Q_BITS];
  logic [DW-1:0]     yr_c [Q_BITS];
  logic [31:0]       xd_c [Q_BITS];
  logic [31:0]       yd_c [Q_BITS];
  logic [Q_BITS-1:0] xq_c [Q_BITS];
  logic [Q_BITS-1:0] yq_c [Q_BITS];
  dside_t            ds_q [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_div
    logic [DW-1:0]     xr_src, yr_src;
    logic [31:0]       xd_src, yd_src;
    logic [Q_BITS-1:0] xq_src, yq_src;
    dside_t            s_src;
    if (i == 0) begin : g_first
      assign xr_src = rx_q;
      assign yr_src = ry_q;
      assign xd_src = den_q;
      assign yd_src = den_q;
      assign xq_src = '0;
      assign yq_src = '0;
      assign s_src  = dv_q;
    end else begin : g_next
      assign xr_src = xr_c[i-1];
      assign yr_src = yr_c[i-1];
      assign xd_src = xd_c[i-1];
      assign yd_src = yd_c[i-1];
      assign xq_src = xq_c[i-1];
      assign yq_src = yq_c[i-1];
      assign s_src  = ds_q[i-1];
    end
    aeap_div_cell #(.DW(DW), .K(Q_BITS - 1 - i)) u_dx (
      .clk_i, .en_i(en), .rem_i(xr_src), .den_i(xd_src), .q_i(xq_src),
      .rem_o(xr_c[i]), .den_o(xd_c[i]), .q_o(xq_c[i])
    );
    aeap_div_cell #(.DW(DW), .K(Q_BITS - 1 - i)) u_dy (
      .clk_i, .en_i(en), .rem_i(yr_src), .den_i(yd_src), .q_i(yq_src),
      .rem_o(yr_c[i]), .den_o(yd_c[i]), .q_o(yq_c[i])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        ds_q[i] <= s_src;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  // Quotients clamp at 2^29, take the sign back and clear at the antipode.
  dside_t            df;
  logic [Q_BITS-1:0] resx, resy, outx, outy;
  logic [Q_BITS-1:0] ox_q, oy_q;
  logic              ov_q;

  always_comb begin
    df   = ds_q[Q_BITS-1];
    resx = (df.satx || (xq_c[Q_BITS-1] > OUT_LIM)) ? OUT_LIM : xq_c[Q_BITS-1];
    resy = (df.saty || (yq_c[Q_BITS-1] > OUT_LIM)) ? OUT_LIM : yq_c[Q_BITS-1];
    outx = df.negx ? -resx : resx;
    outy = df.negy ? -resy : resy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= df.valid ? outx : '0;
      oy_q <= df.valid ? outy : '0;
      ov_q <= df.valid;
    end
  end

  assign m_axis_tdata = {2'b00, oy_q, ox_q};
  assign m_axis_tuser = ov_q;

endmodule

// ===== hdl/aeap_cordic_cell.sv =====
// One micro-rotation of the rotation-mode CORDIC chain, registered.
// Depends on aeap_pkg (cordic_t, atan_val).
module aeap_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  aeap_pkg::cordic_t d_i,
  output aeap_pkg::cordic_t q_o
);
  import aeap_pkg::*;

  localparam logic signed [CW-1:0] ATAN = CW'($signed({2'b00, atan_val(STAGE)}));

  cordic_t d_d, d_q;

  always_comb begin
    if (!d_i.z[CW-1]) begin
      d_d.x = d_i.x - (d_i.y >>> STAGE);
      d_d.y = d_i.y + (d_i.x >>> STAGE);
      d_d.z = d_i.z - ATAN;
    end else begin
      d_d.x = d_i.x + (d_i.y >>> STAGE);
      d_d.y = d_i.y - (d_i.x >>> STAGE);
      d_d.z = d_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign q_o = d_q;

endmodule

// ===== hdl/aeap_sqrt_cell.sv =====
// One root bit of the digit-by-digit integer square root, registered.
// Depends on aeap_pkg (sqrt_t).
module aeap_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  aeap_pkg::sqrt_t d_i,
  output aeap_pkg::sqrt_t q_o
);
  import aeap_pkg::*;

  sqrt_t            d_d, d_q;
  logic [SQ_RW-1:0] rem_n;
  logic [SQ_RW-1:0] trial;

  always_comb begin
    rem_n   = {d_i.rem[SQ_RW-3:0], d_i.rad[2*K+1 -: 2]};
    trial   = SQ_RW'({d_i.root, 2'b01});
    d_d.rad = d_i.rad;
    if (rem_n >= trial) begin
      d_d.rem  = rem_n - trial;
      d_d.root = {d_i.root[SQ_STEPS-2:0], 1'b1};
    end else begin
      d_d.rem  = rem_n;
      d_d.root = {d_i.root[SQ_STEPS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign q_o = d_q;

endmodule

// ===== hdl/aeap_div_cell.sv =====
// One quotient bit of the restoring divider, registered.
// Depends on aeap_pkg (Q_BITS).
module aeap_div_cell #(
  parameter int unsigned DW = 73,
  parameter int unsigned K  = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [DW-1:0]       rem_i,
  input  logic [31:0]         den_i,
  input  logic [aeap_pkg::Q_BITS-1:0] q_i,
  output logic [DW-1:0]       rem_o,
  output logic [31:0]         den_o,
  output logic [aeap_pkg::Q_BITS-1:0] q_o
);
  import aeap_pkg::*;

  logic [DW-1:0]     sub;
  logic [DW-1:0]     rem_d, rem_q;
  logic [Q_BITS-1:0] q_d, q_q;
  logic [31:0]       den_q;

  always_comb begin
    sub = DW'(den_i) << K;
    q_d = q_i;
    if (rem_i >= sub) begin
      rem_d  = rem_i - sub;
      q_d[K] = 1'b1;
    end else begin
      rem_d = rem_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign q_o   = q_q;

endmodule
